// ----- rtl/fsd_pkg.sv -----
// ----------------------------------------------------------------------------
// fsd_pkg
// Shared types, constants and arithmetic helpers for the Floyd-Steinberg
// error-diffusion dither.
// ----------------------------------------------------------------------------
package fsd_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int LINE_W    = 24;
	localparam int WIDTH_W   = 11;
	localparam int HEIGHT_W  = 16;
	localparam int PADDR_W   = 3;
	localparam int PDATA_W   = 32;

	localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);

	localparam logic [2:0] K_RIGHT      = 3'd7;
	localparam logic [2:0] K_DOWN_RIGHT = 3'd1;
	localparam logic [2:0] K_DOWN       = 3'd5;
	localparam logic [2:0] K_DOWN_LEFT  = 3'd3;
	localparam logic [7:0] THRESH       = 8'd127;
	localparam logic [8:0] FULL_SCALE   = 9'd255;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic              en;
		logic [COL_W-1:0]  addr;
		logic [LINE_W-1:0] data;
	} ls_wr_t;

	typedef struct packed {
		logic       pixel_on;
		logic [7:0] right;
		logic [7:0] down_right;
		logic [7:0] down;
		logic [7:0] down_left;
	} diff_res_t;

	// v + signed share, clamped to 0..255
	function automatic logic [7:0] sat_add(input logic [7:0] v, input logic [7:0] s);
		logic signed [9:0] t;
		t = signed'({2'b00, v}) + signed'({{2{s[7]}}, s});
		if (t > 10'sd255) begin
			return 8'hFF;
		end else if (t < 10'sd0) begin
			return 8'h00;
		end else begin
			return t[7:0];
		end
	endfunction

	// (e * k) / 16, truncated toward zero, e in -127..127
	function automatic logic [7:0] share16(input logic signed [8:0] e, input logic [2:0] k);
		logic [8:0] abs_e;
		logic [9:0] prod;
		logic [7:0] q;
		abs_e = e[8] ? 9'(-e) : 9'(e);
		prod  = abs_e[6:0] * k;
		q     = {2'b00, prod[9:4]};
		return e[8] ? 8'(-q) : q;
	endfunction

endpackage

// ----- rtl/fsd_line_store.sv -----
// ----------------------------------------------------------------------------
// fsd_line_store
// Next-row share memory, one entry per column. Registered read with
// write-to-read forwarding; sweeps all entries to zero after reset.
// ----------------------------------------------------------------------------
module fsd_line_store (
	input  logic                              clk,
	input  logic                              arst_n,
	input  fsd_pkg::ls_wr_t                   wr,
	input  logic                              rd_en,
	input  logic [fsd_pkg::COL_W-1:0]         rd_addr,
	output logic [fsd_pkg::LINE_W-1:0]        rd_data,
	output logic                              clr_busy
);

	logic [fsd_pkg::LINE_W-1:0] mem [fsd_pkg::MAX_WIDTH];
	logic [fsd_pkg::LINE_W-1:0] mem_rd_q;
	logic [fsd_pkg::LINE_W-1:0] byp_data_q;
	logic                       byp_q;
	logic                       clr_busy_q;
	logic [fsd_pkg::COL_W-1:0]  clr_addr_q;
	logic                       we;
	logic [fsd_pkg::COL_W-1:0]  wa;
	logic [fsd_pkg::LINE_W-1:0] wd;

	assign we = clr_busy_q | wr.en;
	assign wa = clr_busy_q ? clr_addr_q : wr.addr;
	assign wd = clr_busy_q ? '0 : wr.data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q      <= 1'b0;
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			if (rd_en) begin
				byp_q <= we && (wa == rd_addr);
			end
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (&clr_addr_q) begin
					clr_busy_q <= 1'b0;
				end
			end
		end
	end

	assign rd_data  = byp_q ? byp_data_q : mem_rd_q;
	assign clr_busy = clr_busy_q;

endmodule

// ----- rtl/fsd_diffuse.sv -----
// ----------------------------------------------------------------------------
// fsd_diffuse
// Applies pending shares to one pixel, thresholds it and splits the error
// into the four neighbor shares, or zeroes the shares when diffuse_en is low.
// ----------------------------------------------------------------------------
module fsd_diffuse (
	input  logic [7:0]                  pixel,
	input  logic [fsd_pkg::LINE_W-1:0]  slot,
	input  logic [7:0]                  right_add,
	input  logic                        diffuse_en,
	output fsd_pkg::diff_res_t          res
);

	logic [7:0]        v0, v1, v2, v3;
	logic              on;
	logic signed [8:0] err;

	always_comb begin
		v0  = fsd_pkg::sat_add(pixel, slot[7:0]);
		v1  = fsd_pkg::sat_add(v0, slot[15:8]);
		v2  = fsd_pkg::sat_add(v1, slot[23:16]);
		v3  = fsd_pkg::sat_add(v2, right_add);
		on  = v3 > fsd_pkg::THRESH;
		err = on ? signed'({1'b0, v3} - fsd_pkg::FULL_SCALE) : signed'({1'b0, v3});

		res.pixel_on = on;
		if (diffuse_en) begin
			res.right      = fsd_pkg::share16(err, fsd_pkg::K_RIGHT);
			res.down_right = fsd_pkg::share16(err, fsd_pkg::K_DOWN_RIGHT);
			res.down       = fsd_pkg::share16(err, fsd_pkg::K_DOWN);
			res.down_left  = fsd_pkg::share16(err, fsd_pkg::K_DOWN_LEFT);
		end else begin
			res.right      = '0;
			res.down_right = '0;
			res.down       = '0;
			res.down_left  = '0;
		end
	end

endmodule

// ----- rtl/floyd_steinberg_dither.sv -----
// Pipeline: an accepted pixel is registered in stage 1, then its result in the
// output register; a stalled output (out_ready low) holds stage 1.
// Throughput: one pixel per cycle unless out_ready stalls the output; the line
// store has one write and one read port. Reset: asynchronous, active low; then
// the line store is swept to zero, with in_ready low. Config resets to 640 x 480.
// ----------------------------------------------------------------------------
// floyd_steinberg_dither
// Streaming Floyd-Steinberg dither, 8-bit grey in, one bit per pixel out.
// ----------------------------------------------------------------------------
module floyd_steinberg_dither (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     pixel_in,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           pixel_on,
	output logic                           row_end,
	output logic                           frame_end,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fsd_pkg::PADDR_W-1:0]    paddr,
	input  logic [fsd_pkg::PDATA_W-1:0]    pwdata,
	output logic [fsd_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready
);

	localparam int CW = fsd_pkg::COL_W;
	localparam int HW = fsd_pkg::HEIGHT_W;
	localparam int WW = fsd_pkg::WIDTH_W;

	logic [WW-1:0]              width_q;
	logic [HW-1:0]              height_q;
	logic [CW-1:0]              col_q;
	logic [HW-1:0]              row_q;
	logic [7:0]                 right_q;
	logic [7:0]                 pend_q;
	logic [CW-1:0]              hold_addr_q;
	logic [15:0]                hold_low_q;

	logic                       valid_s1;
	logic [7:0]                 pix_s1;
	logic [CW-1:0]              col_s1;
	logic                       row_end_s1;
	logic                       last_row_s1;

	logic                       out_valid_q;
	logic                       pixel_on_q;
	logic                       row_end_q;
	logic                       frame_end_q;

	logic [CW-1:0]              last_col;
	logic [HW-1:0]              last_row_idx;
	logic                       acc_row_end;
	logic                       acc_last_row;
	logic                       accept;
	logic                       adv;
	logic                       clr_busy;
	logic                       cfg_wr;
	fsd_pkg::reg_idx_t          reg_idx;
	fsd_pkg::ls_wr_t            ls_wr;
	logic [fsd_pkg::LINE_W-1:0] rd_data;
	logic [fsd_pkg::LINE_W-1:0] slot;
	logic                       diffuse_en;
	fsd_pkg::diff_res_t         res;

	// configuration port
	assign pready  = 1'b1;
	assign reg_idx = fsd_pkg::reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite;

	always_comb begin
		unique case (reg_idx)
			fsd_pkg::REG_WIDTH:  prdata = fsd_pkg::PDATA_W'(width_q);
			fsd_pkg::REG_HEIGHT: prdata = fsd_pkg::PDATA_W'(height_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= fsd_pkg::WIDTH_RST;
			height_q <= fsd_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fsd_pkg::REG_WIDTH:  width_q  <= pwdata[WW-1:0];
				fsd_pkg::REG_HEIGHT: height_q <= pwdata[HW-1:0];
				default: ;
			endcase
		end
	end

	// frame position
	always_comb begin
		if (width_q <= WW'(1)) begin
			last_col = '0;
		end else if (width_q > WW'(fsd_pkg::MAX_WIDTH)) begin
			last_col = CW'(fsd_pkg::MAX_WIDTH - 1);
		end else begin
			last_col = CW'(width_q - WW'(1));
		end
		last_row_idx = (height_q == '0) ? '0 : height_q - HW'(1);
		acc_row_end  = col_q >= last_col;
		acc_last_row = row_q >= last_row_idx;
	end

	// handshake
	assign adv      = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~clr_busy & (~valid_s1 | adv);
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (acc_row_end) begin
					col_q <= '0;
					row_q <= acc_last_row ? '0 : row_q + HW'(1);
				end else begin
					col_q <= col_q + CW'(1);
				end
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1      <= pixel_in;
			col_s1      <= col_q;
			row_end_s1  <= acc_row_end;
			last_row_s1 <= acc_last_row;
		end
	end

	// line store
	fsd_line_store u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (ls_wr),
		.rd_en    (accept),
		.rd_addr  (col_q),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	// most recent slot is held back until its down-left share is known
	assign slot       = (hold_addr_q == col_s1) ? {8'h00, hold_low_q} : rd_data;
	assign diffuse_en = ~last_row_s1 & ~row_end_s1 & (col_s1 != '0);

	fsd_diffuse u_diffuse (
		.pixel      (pix_s1),
		.slot       (slot),
		.right_add  (right_q),
		.diffuse_en (diffuse_en),
		.res        (res)
	);

	always_comb begin
		ls_wr.en = adv;
		if (col_s1 != '0) begin
			ls_wr.addr = col_s1 - CW'(1);
			ls_wr.data = {res.down_left, hold_low_q};
		end else begin
			ls_wr.addr = hold_addr_q;
			ls_wr.data = {8'h00, hold_low_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			right_q     <= '0;
			pend_q      <= '0;
			hold_addr_q <= '0;
			hold_low_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				right_q     <= res.right;
				pend_q      <= res.down_right;
				hold_addr_q <= col_s1;
				hold_low_q  <= {res.down, pend_q};
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pixel_on_q  <= res.pixel_on;
			row_end_q   <= row_end_s1;
			frame_end_q <= row_end_s1 & last_row_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_on  = pixel_on_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

	// checks
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready)
		else $error("transaction accepted during line store clear");

	a_hold_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && (col_s1 != '0) |-> hold_addr_q == col_s1 - CW'(1))
		else $error("held slot is not the left neighbor column");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && acc_row_end |=> col_q == '0)
		else $error("column count did not wrap at row end");

	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> row_end_q)
		else $error("frame end without row end");

	a_s1_drain: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !accept |=> !valid_s1)
		else $error("stage 1 kept a transaction it handed on");

endmodule
